/* design/zplc_pkg.sv */
// ----------------------------------------------------------------------------
// zplc_pkg
// Shared types and constants for the zero-padded linear convolution core.
// ----------------------------------------------------------------------------
package zplc_pkg;

  // Result and field widths
  localparam int OUT_BITS     = 37;
  localparam int SPAN_BITS    = 5;
  localparam int TAP_IDX_BITS = 5;

  // APB register file
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;

  // Item opcodes
  localparam logic OP_TAP    = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Register indexes (decoded from paddr[2])
  localparam logic REG_LEFT_SPAN  = 1'b0;
  localparam logic REG_RIGHT_SPAN = 1'b1;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic tap_we;  // load coefficient into the cell whose index matches
    logic shift;   // history moves one cell down the chain
    logic clear;   // zero all history at end of block
  } zplc_ctl_t;

endpackage

/* design/zplc_cfg.sv */
// ----------------------------------------------------------------------------
// zplc_cfg
// APB span registers and span clamping to the chain length.
// ----------------------------------------------------------------------------
module zplc_cfg
  import zplc_pkg::*;
#(
  parameter int MAX_TAPS = 32,
  parameter int CW       = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [CW-1:0]     r_eff,
  output logic [CW-1:0]     ntaps
);

  logic [SPAN_BITS-1:0] left_span_r, left_span_nxt;
  logic [SPAN_BITS-1:0] right_span_r, right_span_nxt;
  logic                 reg_idx;
  logic                 wr_en;
  logic [CW-1:0]        lim, r_ext, l_ext, l_lim, l_eff;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    left_span_nxt  = left_span_r;
    right_span_nxt = right_span_r;
    if (wr_en) begin
      case (reg_idx)
        REG_LEFT_SPAN:  left_span_nxt  = pwdata[SPAN_BITS-1:0];
        REG_RIGHT_SPAN: right_span_nxt = pwdata[SPAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_span_r  <= '0;
      right_span_r <= '0;
    end else begin
      left_span_r  <= left_span_nxt;
      right_span_r <= right_span_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LEFT_SPAN:  prdata = CFG_DW'(left_span_r);
      REG_RIGHT_SPAN: prdata = CFG_DW'(right_span_r);
      default:        prdata = '0;
    endcase
  end

  // right span limited to the chain, left span to what remains
  assign lim   = CW'(MAX_TAPS - 1);
  assign r_ext = CW'(right_span_r);
  assign l_ext = CW'(left_span_r);
  assign r_eff = (r_ext > lim) ? lim : r_ext;
  assign l_lim = lim - r_eff;
  assign l_eff = (l_ext > l_lim) ? l_lim : l_ext;
  assign ntaps = l_eff + r_eff + CW'(1);

endmodule

/* design/zplc_cell.sv */
// ----------------------------------------------------------------------------
// zplc_cell
// One tap of the chain: coefficient, history slot, product and a stage of
// the accumulation wave.
// ----------------------------------------------------------------------------
module zplc_cell
  import zplc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int CW          = 7,
  parameter int IDX         = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  zplc_ctl_t                     ctl,
  input  logic [CW-1:0]                 wr_idx,
  input  logic signed [SAMPLE_BITS-1:0] tap_in,
  input  logic [CW-1:0]                 ntaps,
  input  logic signed [SAMPLE_BITS-1:0] hist_in,
  output logic signed [SAMPLE_BITS-1:0] hist_out,
  input  logic signed [OUT_BITS-1:0]    acc_in,
  input  logic                          vld_in,
  output logic signed [OUT_BITS-1:0]    acc_out,
  output logic                          vld_out
);

  logic signed [SAMPLE_BITS-1:0]   tap_r, tap_nxt;
  logic signed [SAMPLE_BITS-1:0]   hist_r, hist_nxt;
  logic signed [2*SAMPLE_BITS-1:0] prod_r;
  logic signed [OUT_BITS-1:0]      acc_r;
  logic                            vld_r;
  logic signed [63:0]              prod_ext;
  logic signed [OUT_BITS-1:0]      addend;

  always_comb begin
    tap_nxt = tap_r;
    if (ctl.tap_we && (wr_idx == CW'(IDX))) begin
      tap_nxt = tap_in;
    end
  end

  always_comb begin
    hist_nxt = hist_r;
    if (ctl.clear) begin
      hist_nxt = '0;
    end else if (ctl.shift) begin
      hist_nxt = hist_in;
    end
  end

  // taps past the active span contribute nothing
  assign prod_ext = 64'(prod_r);
  assign addend   = (CW'(IDX) < ntaps) ? prod_ext[OUT_BITS-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r  <= '0;
      hist_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      tap_r  <= tap_nxt;
      hist_r <= hist_nxt;
      vld_r  <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= (2*SAMPLE_BITS)'(tap_r) * (2*SAMPLE_BITS)'(hist_r);
    if (vld_in) begin
      acc_r <= acc_in + addend;
    end
  end

  assign hist_out = hist_r;
  assign acc_out  = acc_r;
  assign vld_out  = vld_r;

endmodule

/* design/zero_padded_linear_convolution_core.sv */
// ----------------------------------------------------------------------------
// zero_padded_linear_convolution_core
// Block-wise non-causal direct-form FIR with zero padding at both ends.
// ----------------------------------------------------------------------------
// Usage: load coefficients with op=0 transfers (slot tap_index holds offset
// tap_index - right_span), then stream a block of samples with op=1, the
// final one flagged by last_sample. Each sample shifts into a chain of
// MAX_TAPS cells; once right_span samples have been seen, every sample
// produces one output. The last sample also drains right_span zero samples
// through the chain, emits the remaining outputs with out_last on the final
// one, and clears the history for the next block. Spans are clamped so the
// active window never exceeds MAX_TAPS taps. Each output is formed by a
// partial-sum wave that walks the cell chain one cell per clock. A sample
// that produces an output holds the input through shift, settle, launch,
// the sum steps, push and next; a sample that produces no output goes
// from shift straight to next. A last sample adds right_span flush steps:
// one that emits an output runs shift, settle, launch, sum, push and next,
// one that does not only shifts in next. A result still held by the sink
// stalls the push step. One input transfer is in work at a time; the
// output register lets the next transfer be accepted while the previous
// result is still waiting.
// Span registers must only be written while the core is idle.
// ----------------------------------------------------------------------------
module zero_padded_linear_convolution_core
  import zplc_pkg::*;
#(
  parameter int MAX_TAPS    = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample / tap input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [TAP_IDX_BITS-1:0]       in_tap_index,
  input  logic signed [SAMPLE_BITS-1:0] in_tap_value,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last_sample,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_BITS-1:0]    out_value,
  output logic                          out_last,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CFG_AW-1:0]             paddr,
  input  logic [CFG_DW-1:0]             pwdata,
  output logic [CFG_DW-1:0]             prdata,
  output logic                          pready
);

  // counter width: holds position + flush count (< 2*MAX_TAPS) and spans
  localparam int CW_A   = $clog2(MAX_TAPS) + 2;
  localparam int CW     = (CW_A > SPAN_BITS + 1) ? CW_A : SPAN_BITS + 1;
  localparam int SEEN_W = $clog2(MAX_TAPS + 1);

  // Sequencer:
  //   IDLE   - take transfers; a sample shifts into the chain
  //   SETTLE - products catch up with the new history
  //   LAUNCH - start a partial-sum wave at cell 0
  //   SUM    - wave walks the chain
  //   PUSH   - park the sum in the output register
  //   NEXT   - shift a flush zero, or finish the transfer
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SETTLE = 6'b000010,
    ST_LAUNCH = 6'b000100,
    ST_SUM    = 6'b001000,
    ST_PUSH   = 6'b010000,
    ST_NEXT   = 6'b100000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [SEEN_W-1:0]       seen_r, seen_nxt;
  logic [CW-1:0]           ptr_r, ptr_nxt;
  logic [CW-1:0]           rem_r, rem_nxt;
  logic                    last_r, last_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [OUT_BITS-1:0] out_value_r;
  logic                    out_last_r;
  logic                    out_load;

  logic [CW-1:0]           r_eff;
  logic [CW-1:0]           ntaps;
  logic                    in_xfer;
  logic                    launch;
  zplc_ctl_t               ctl;
  logic signed [SAMPLE_BITS-1:0] shift_data;

  logic signed [SAMPLE_BITS-1:0] hist_chain [0:MAX_TAPS];
  logic signed [OUT_BITS-1:0]    acc_chain  [0:MAX_TAPS];
  logic [MAX_TAPS:0]             vld_chain;
  logic                          tail_vld;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  zplc_cfg #(
    .MAX_TAPS (MAX_TAPS),
    .CW       (CW)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .r_eff   (r_eff),
    .ntaps   (ntaps)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid & in_ready;
  assign launch   = (state_r == ST_LAUNCH);
  assign tail_vld = vld_chain[MAX_TAPS];
  assign out_load = (state_r == ST_PUSH) && (!out_valid_r || out_ready);

  // zeros feed the chain during the flush
  assign shift_data = (state_r == ST_IDLE) ? in_sample : '0;

  always_comb begin
    state_nxt  = state_r;
    seen_nxt   = seen_r;
    ptr_nxt    = ptr_r;
    rem_nxt    = rem_r;
    last_nxt   = last_r;
    ctl.tap_we = 1'b0;
    ctl.shift  = 1'b0;
    ctl.clear  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_op == OP_TAP) begin
            ctl.tap_we = 1'b1;
          end else begin
            ctl.shift = 1'b1;
            ptr_nxt   = CW'(seen_r);
            if (seen_r != SEEN_W'(MAX_TAPS)) begin
              seen_nxt = seen_r + SEEN_W'(1);
            end
            last_nxt  = in_last_sample;
            rem_nxt   = in_last_sample ? r_eff : '0;
            state_nxt = (CW'(seen_r) >= r_eff) ? ST_SETTLE : ST_NEXT;
          end
        end
      end
      ST_SETTLE: state_nxt = ST_LAUNCH;
      ST_LAUNCH: state_nxt = ST_SUM;
      ST_SUM: begin
        if (tail_vld) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_load) begin
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (rem_r != '0) begin
          ctl.shift = 1'b1;
          rem_nxt   = rem_r - CW'(1);
          ptr_nxt   = ptr_r + CW'(1);
          state_nxt = ((ptr_r + CW'(1)) >= r_eff) ? ST_SETTLE : ST_NEXT;
        end else begin
          if (last_r) begin
            ctl.clear = 1'b1;
            seen_nxt  = '0;
            last_nxt  = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seen_r      <= '0;
      ptr_r       <= '0;
      rem_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      ptr_r       <= ptr_nxt;
      rem_r       <= rem_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register; out_last marks the output of a block's last sample once no flush steps remain
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= acc_chain[MAX_TAPS];
      out_last_r  <= last_r && (rem_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  // --------------------------------------------------------------------------
  // Cell chain: history moves down on shift, the sum wave one cell per clock
  // --------------------------------------------------------------------------
  assign hist_chain[0] = shift_data;
  assign acc_chain[0]  = '0;
  assign vld_chain[0]  = launch;

  for (genvar s = 0; s < MAX_TAPS; s++) begin : g_cell
    zplc_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CW          (CW),
      .IDX         (s)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .wr_idx   (CW'(in_tap_index)),
      .tap_in   (in_tap_value),
      .ntaps    (ntaps),
      .hist_in  (hist_chain[s]),
      .hist_out (hist_chain[s+1]),
      .acc_in   (acc_chain[s]),
      .vld_in   (vld_chain[s]),
      .acc_out  (acc_chain[s+1]),
      .vld_out  (vld_chain[s+1])
    );
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // only one sum wave in the chain at a time
  a_one_wave: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_chain) <= 1)
    else $error("more than one partial-sum wave in flight");

  // a launched wave passes through every cell register and reaches the tail
  a_wave_len: assert property (@(posedge clk) disable iff (!rst_n)
    launch |-> ##MAX_TAPS tail_vld)
    else $error("sum wave did not reach chain tail on time");

  // tail result is always captured by the push step
  a_tail_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) && tail_vld |=> (state_r == ST_PUSH))
    else $error("tail sum not moved to push");

  // flush steps only exist for a block's last sample
  a_rem_last: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != '0) |-> last_r)
    else $error("flush count without last sample");

  // no new transfer is taken while a wave is running
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (vld_chain == '0))
    else $error("input ready while chain busy");

endmodule
